// File: hdl/record_list_sort_remove_core_defines.svh
// Assertion macros shared by the record list checker.
`ifndef RECORD_LIST_SORT_REMOVE_CORE_DEFINES_SVH
`define RECORD_LIST_SORT_REMOVE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define RLSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define RLSR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/rlsr_pkg.sv
// Types and constants shared by the record list sort and remove block.
package rlsr_pkg;

  // Number of records the list can hold.
  localparam int unsigned DEPTH = 32;
  // A dump emits at most this many records.
  localparam int unsigned OUT_LIMIT = 32;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned LAST_POS = ((DEPTH < OUT_LIMIT) ? DEPTH : OUT_LIMIT) - 1;

  localparam int unsigned CMD_W = 3;
  localparam int unsigned POS_W = 5;
  localparam int unsigned ECNT_W = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_SORT   = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_DUMP   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RESP,
    S_SORT_RDI,
    S_SORT_LDI,
    S_SORT_RDJ,
    S_SORT_CMP,
    S_SORT_WRI,
    S_RM_RD,
    S_RM_CHK,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_e;

  // One stored record.
  typedef struct packed {
    logic signed [31:0] id;
    logic [63:0]        name_0;
    logic [63:0]        name_1;
    logic [31:0]        name_2;
  } rec_t;

  // Access request from the sequencer to the record store.
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    rec_t             wr_data;
  } mem_req_t;

endpackage

// File: hdl/rlsr_cmd_if.sv
// Command channel: valid/ready handshake with one command and its record.
interface rlsr_cmd_if;
  import rlsr_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic signed [31:0] key_id;
  logic [63:0]        name_0;
  logic [63:0]        name_1;
  logic [31:0]        name_2;

  modport source (output valid, cmd, key_id, name_0, name_1, name_2, input ready);
  modport sink (input valid, cmd, key_id, name_0, name_1, name_2, output ready);
endinterface

// File: hdl/rlsr_res_if.sv
// Result channel: valid/ready handshake with one result item.
interface rlsr_res_if;
  import rlsr_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [POS_W-1:0]   position;
  logic signed [31:0] rec_id;
  logic [63:0]        rec_name_0;
  logic [63:0]        rec_name_1;
  logic [31:0]        rec_name_2;
  logic               final_item;
  logic [ECNT_W-1:0]  entry_count;

  modport source (output valid, status, position, rec_id, rec_name_0, rec_name_1,
                  rec_name_2, final_item, entry_count, input ready);
  modport sink (input valid, status, position, rec_id, rec_name_0, rec_name_1,
                rec_name_2, final_item, entry_count, output ready);
endinterface

// File: hdl/record_list_sort_remove_core.sv
// Top level of the record list: an ordered list of id and name records.
// Commands arrive on cmd_i (clear, insert, sort, remove, dump); results
// leave on res_o. Both channels transfer when valid and ready are high.
// One command is worked at a time: cmd_i.ready is high only while the
// sequencer is idle, but it stays high while a finished result waits in
// the output register. Records live in a store with one read port and
// registered read data, so each step that reads a record issues the read
// in one state and uses the data in the next. Clear and insert load their
// result from S_RESP. Remove reads the entries in turn; sort compares each
// entry with every later one. Dump: one result per record, the last
// marked final_item. When the receiver stalls, the result register holds
// and the sequencer waits at the next result. Reset empties the list at
// once; the store needs no clearing pass since only held entries are read.
module record_list_sort_remove_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  rlsr_cmd_if.sink   cmd_i,
  rlsr_res_if.source res_o
);
  import rlsr_pkg::*;

  mem_req_t mem_req;
  rec_t     rd_data;

  // Sequencer and result register.
  rlsr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd_i),
    .res_o     (res_o),
    .req_o     (mem_req),
    .rd_data_i (rd_data)
  );

  // Record memory.
  rlsr_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

endmodule

// File: hdl/rlsr_store.sv
// Record store: one write port and one read port with registered read data.
module rlsr_store (
  input  logic              clk_i,
  input  rlsr_pkg::mem_req_t req_i,
  output rlsr_pkg::rec_t    rd_data_o
);
  import rlsr_pkg::*;

  rec_t mem_q [DEPTH];
  rec_t rd_data_q;

  // Write first in program order; a read of the same entry in the same
  // cycle returns the old contents.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hdl/rlsr_ctrl.sv
// Command sequencer: walks the record store and drives the result register.
module rlsr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  rlsr_cmd_if.sink           cmd_i,
  rlsr_res_if.source         res_o,
  output rlsr_pkg::mem_req_t req_o,
  input  rlsr_pkg::rec_t     rd_data_i
);
  import rlsr_pkg::*;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   jdx_q, jdx_d;
  logic               found_q, found_d;
  status_e            status_q, status_d;
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] key_q, key_d;
  rec_t               cur_q, cur_d;

  // Result register payload.
  status_e            o_status_q, o_status_d;
  logic [POS_W-1:0]   o_pos_q, o_pos_d;
  rec_t               o_rec_q, o_rec_d;
  logic               o_final_q, o_final_d;
  logic [ECNT_W-1:0]  o_count_q, o_count_d;

  logic               out_free;
  logic               accept;
  logic               dump_last;
  logic               id_match;

  assign out_free  = !out_valid_q || res_o.ready;
  assign accept    = cmd_i.valid && cmd_i.ready;
  assign dump_last = ((idx_q + CNT_W'(1)) == count_q) || (idx_q == CNT_W'(LAST_POS));
  assign id_match  = (rd_data_i.id == key_q);

  assign cmd_i.ready = (state_q == S_IDLE);

  // Next state, store requests and result loading.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    jdx_d       = jdx_q;
    found_d     = found_q;
    status_d    = status_q;
    key_d       = key_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q;
    o_status_d  = o_status_q;
    o_pos_d     = o_pos_q;
    o_rec_d     = o_rec_q;
    o_final_d   = o_final_q;
    o_count_d   = o_count_q;

    req_o         = '0;
    req_o.wr_data = cur_q;

    // The receiver took the pending result.
    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          key_d    = cmd_i.key_id;
          idx_d    = '0;
          found_d  = 1'b0;
          status_d = ST_OK;
          state_d  = S_RESP;
          case (cmd_e'(cmd_i.cmd))
            CMD_CLEAR: begin
              count_d = '0;
            end
            CMD_INSERT: begin
              if (count_q == CNT_W'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                req_o.wr_en           = 1'b1;
                req_o.wr_addr         = count_q[IDX_W-1:0];
                req_o.wr_data.id      = cmd_i.key_id;
                req_o.wr_data.name_0  = cmd_i.name_0;
                req_o.wr_data.name_1  = cmd_i.name_1;
                req_o.wr_data.name_2  = cmd_i.name_2;
                count_d               = count_q + CNT_W'(1);
              end
            end
            CMD_SORT: begin
              if (count_q > CNT_W'(1)) begin
                state_d = S_SORT_RDI;
              end
            end
            CMD_REMOVE: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                state_d = S_RM_RD;
              end
            end
            CMD_DUMP: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                state_d = S_DUMP_RD;
              end
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
        end
      end

      // Single result of a command other than a non-empty dump.
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_status_d  = status_q;
          o_pos_d     = '0;
          o_rec_d     = '0;
          o_final_d   = 1'b1;
          o_count_d   = ECNT_W'(count_q);
          state_d     = S_IDLE;
        end
      end

      // Exchange sort: entry i is held in cur_q while later entries stream by.
      S_SORT_RDI: begin
        req_o.rd_en   = 1'b1;
        req_o.rd_addr = idx_q[IDX_W-1:0];
        state_d       = S_SORT_LDI;
      end
      S_SORT_LDI: begin
        cur_d   = rd_data_i;
        jdx_d   = idx_q + CNT_W'(1);
        state_d = S_SORT_RDJ;
      end
      S_SORT_RDJ: begin
        req_o.rd_en   = 1'b1;
        req_o.rd_addr = jdx_q[IDX_W-1:0];
        state_d       = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        if ($signed(cur_q.id) > $signed(rd_data_i.id)) begin
          req_o.wr_en   = 1'b1;
          req_o.wr_addr = jdx_q[IDX_W-1:0];
          req_o.wr_data = cur_q;
          cur_d         = rd_data_i;
        end
        if ((jdx_q + CNT_W'(1)) == count_q) begin
          state_d = S_SORT_WRI;
        end else begin
          jdx_d   = jdx_q + CNT_W'(1);
          state_d = S_SORT_RDJ;
        end
      end
      S_SORT_WRI: begin
        req_o.wr_en   = 1'b1;
        req_o.wr_addr = idx_q[IDX_W-1:0];
        req_o.wr_data = cur_q;
        if ((idx_q + CNT_W'(2)) == count_q) begin
          state_d = S_RESP;
        end else begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_SORT_RDI;
        end
      end

      // Remove: search and, once the match is past, shift each entry down one.
      S_RM_RD: begin
        req_o.rd_en   = 1'b1;
        req_o.rd_addr = idx_q[IDX_W-1:0];
        state_d       = S_RM_CHK;
      end
      S_RM_CHK: begin
        if (found_q) begin
          req_o.wr_en   = 1'b1;
          req_o.wr_addr = idx_q[IDX_W-1:0] - IDX_W'(1);
          req_o.wr_data = rd_data_i;
        end else if (id_match) begin
          found_d = 1'b1;
        end
        if ((idx_q + CNT_W'(1)) == count_q) begin
          if (found_q || id_match) begin
            count_d  = count_q - CNT_W'(1);
            status_d = ST_OK;
          end else begin
            status_d = ST_NOT_FOUND;
          end
          state_d = S_RESP;
        end else begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_RM_RD;
        end
      end

      // Dump: one read and one result transfer per record.
      S_DUMP_RD: begin
        req_o.rd_en   = 1'b1;
        req_o.rd_addr = idx_q[IDX_W-1:0];
        state_d       = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_status_d  = ST_OK;
          o_pos_d     = POS_W'(idx_q);
          o_rec_d     = rd_data_i;
          o_final_d   = dump_last;
          o_count_d   = ECNT_W'(count_q);
          if (dump_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + CNT_W'(1);
            state_d = S_DUMP_RD;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      idx_q       <= '0;
      jdx_q       <= '0;
      status_q    <= ST_OK;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
      idx_q       <= idx_d;
      jdx_q       <= jdx_d;
      status_q    <= status_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    cur_q      <= cur_d;
    o_status_q <= o_status_d;
    o_pos_q    <= o_pos_d;
    o_rec_q    <= o_rec_d;
    o_final_q  <= o_final_d;
    o_count_q  <= o_count_d;
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.status      = o_status_q;
  assign res_o.position    = o_pos_q;
  assign res_o.rec_id      = o_rec_q.id;
  assign res_o.rec_name_0  = o_rec_q.name_0;
  assign res_o.rec_name_1  = o_rec_q.name_1;
  assign res_o.rec_name_2  = o_rec_q.name_2;
  assign res_o.final_item  = o_final_q;
  assign res_o.entry_count = o_count_q;

endmodule

// File: hdl/rlsr_checker.sv
// Port-level checks on the result channel of the record list, with bind.
`include "record_list_sort_remove_core_defines.svh"

module rlsr_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   res_valid_i,
  input logic                   res_ready_i,
  input logic [1:0]             status_i,
  input logic [rlsr_pkg::POS_W-1:0]  position_i,
  input logic signed [31:0]     rec_id_i,
  input logic                   final_item_i,
  input logic [rlsr_pkg::ECNT_W-1:0] entry_count_i
);
  import rlsr_pkg::*;

  // A stalled result stays offered with the same record.
  `RLSR_ASSERT_NXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i && $stable(rec_id_i) && $stable(final_item_i), "result dropped or changed while stalled")

  // An error status ends the command.
  `RLSR_ASSERT_IMP(a_err_final, res_valid_i && (status_i != ST_OK), final_item_i, "error result without final_item")

  // An error result carries no record.
  `RLSR_ASSERT_IMP(a_err_blank, res_valid_i && (status_i != ST_OK), (position_i == '0) && (rec_id_i == '0), "error result carries record data")

  // An empty-list report comes with a count of zero.
  `RLSR_ASSERT_IMP(a_empty_cnt, res_valid_i && (status_i == ST_EMPTY), entry_count_i == '0, "empty status with nonzero count")

endmodule

bind record_list_sort_remove_core rlsr_checker u_rlsr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .status_i      (res_o.status),
  .position_i    (res_o.position),
  .rec_id_i      (res_o.rec_id),
  .final_item_i  (res_o.final_item),
  .entry_count_i (res_o.entry_count)
);
